// ===== rtl/art_pkg.sv =====
// Shared types and constants for the address range table.
// Used by every module of the block except art_ram; depends on nothing.
`default_nettype none

package art_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PADDR_W = 5;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MATCH = 2'd1;
	localparam logic [1:0] KIND_CROSS = 2'd2;

	localparam logic [3:0] RIGHTS_VALID = 4'd3;
	localparam logic [3:0] CACHE_NONE = 4'd0;
	localparam logic [1:0] MODE_TIMING = 2'd0;
	localparam logic [1:0] MODE_CAPACITY = 2'd1;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_PAGE = 2'd1;
	localparam logic [1:0] REG_CAPACITY = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] address;
		logic [63:0] size_bytes;
		logic [1:0]  range_mode;
		logic [3:0]  access_rights;
		logic [3:0]  cache_kind;
		logic [31:0] stream_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  lookup_kind;
		logic [63:0] hit_base;
		logic [63:0] hit_length;
		logic [63:0] hit_offset;
		logic [31:0] hit_id;
		logic        hit_mode;
		logic [1:0]  hit_rights;
		logic [31:0] hit_stream;
		logic [6:0]  entries_in_use;
	} rsp_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		logic [63:0] offset;
		logic [31:0] id;
		logic        mode;
		logic [1:0]  rights;
		logic [31:0] stream;
	} entry_t;

	typedef struct packed {
		logic        enabled;
		logic [31:0] page_size;
		logic [63:0] capacity;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_PREP, OP_REM, OP_EXT, OP_CAP, OP_SRD, OP_SCMP,
		OP_LRD, OP_LCHK, OP_NLRD, OP_NLCHK, OP_NHRD, OP_NHCHK, OP_SH_RD,
		OP_SH_WR, OP_INS, OP_RRD, OP_RCHK, OP_DONE
	} dp_op_t;

	typedef struct packed {
		logic fin;
		logic rem_last;
		logic srch_done;
		logic sh_done;
		logic is_add;
		logic is_lookup;
		logic out_free;
	} dp_st_t;

endpackage

`default_nettype wire

// ===== rtl/art_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// ===== rtl/art_ctrl.sv =====
// Sequencer for the range table: steps the datapath through checks,
// binary search, entry shifting and result hand-off. Depends on art_pkg.
`default_nettype none

module art_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire art_pkg::dp_st_t st,
	output art_pkg::dp_op_t      op
);
	import art_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_PREP  = 19'h00002,
		S_REM   = 19'h00004,
		S_EXT   = 19'h00008,
		S_CAP   = 19'h00010,
		S_SRD   = 19'h00020,
		S_SCMP  = 19'h00040,
		S_LRD   = 19'h00080,
		S_LCHK  = 19'h00100,
		S_NLRD  = 19'h00200,
		S_NLCHK = 19'h00400,
		S_NHRD  = 19'h00800,
		S_NHCHK = 19'h01000,
		S_SHR   = 19'h02000,
		S_SHW   = 19'h04000,
		S_INS   = 19'h08000,
		S_RRD   = 19'h10000,
		S_RCHK  = 19'h20000,
		S_DONE  = 19'h40000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	// command decode depends on the state and req_valid only, so datapath status never feeds back into it
	always_comb begin
		unique case (state_q)
			S_IDLE: op = req_valid ? OP_LOAD : OP_NOP;
			S_PREP: op = OP_PREP;
			S_REM: op = OP_REM;
			S_EXT: op = OP_EXT;
			S_CAP: op = OP_CAP;
			S_SRD: op = OP_SRD;
			S_SCMP: op = OP_SCMP;
			S_LRD: op = OP_LRD;
			S_LCHK: op = OP_LCHK;
			S_NLRD: op = OP_NLRD;
			S_NLCHK: op = OP_NLCHK;
			S_NHRD: op = OP_NHRD;
			S_NHCHK: op = OP_NHCHK;
			S_SHR: op = OP_SH_RD;
			S_SHW: op = OP_SH_WR;
			S_INS: op = OP_INS;
			S_RRD: op = OP_RRD;
			S_RCHK: op = OP_RCHK;
			S_DONE: op = OP_DONE;
			default: op = OP_NOP;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_PREP;
			end
			S_PREP: begin
				if (st.fin) state_d = S_DONE;
				else if (st.is_add) state_d = S_REM;
				else state_d = S_SRD;
			end
			S_REM: begin
				if (st.rem_last) state_d = S_EXT;
			end
			S_EXT: state_d = S_CAP;
			S_CAP: state_d = st.fin ? S_DONE : S_SRD;
			S_SRD: begin
				if (!st.srch_done) state_d = S_SCMP;
				else if (st.fin) state_d = S_DONE;
				else if (st.is_lookup) state_d = S_LRD;
				else if (st.is_add) state_d = S_NLRD;
				else state_d = S_RRD;
			end
			S_SCMP: state_d = S_SRD;
			S_LRD: state_d = S_LCHK;
			S_LCHK: state_d = S_DONE;
			S_NLRD: state_d = S_NLCHK;
			S_NLCHK: state_d = st.fin ? S_DONE : S_NHRD;
			S_NHRD: state_d = S_NHCHK;
			S_NHCHK: state_d = st.fin ? S_DONE : S_SHR;
			S_SHR: begin
				if (!st.sh_done) state_d = S_SHW;
				else if (st.is_add) state_d = S_INS;
				else state_d = S_DONE;
			end
			S_SHW: state_d = S_SHR;
			S_INS: state_d = S_DONE;
			S_RRD: state_d = S_RCHK;
			S_RCHK: state_d = st.fin ? S_DONE : S_SHR;
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

`default_nettype wire

// ===== rtl/art_dp.sv =====
// Datapath of the range table: item and result registers, table state,
// remainder unit, search bounds and the entry RAM. Depends on art_pkg, art_ram.
`default_nettype none

module art_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire art_pkg::cfg_t   cfg,
	input  wire art_pkg::req_t   req,
	input  wire art_pkg::dp_op_t op,
	output art_pkg::dp_st_t      st,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output art_pkg::rsp_t        rsp
);
	import art_pkg::*;

	req_t             item_q;
	rsp_t             res_q;
	rsp_t             res_out;
	logic [CNT_W-1:0] count_q, lo_q, hi_q, ptr_q;
	logic [31:0]      next_id_q;
	logic [63:0]      next_off_q, extent_q;
	logic [31:0]      rem_q;
	logic [5:0]       bit_q;

	logic             is_add, is_rem, is_lookup;
	logic [63:0]      page64, addr, len;
	logic             bad_arg, prep_fin;
	logic [1:0]       prep_status;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [32:0]      rem_sh, rem_sub;
	logic [31:0]      rem_nx, gap;
	logic             cap_fail, srch_done, srch_fin, pred;
	logic [63:0]      lk_off;
	logic [64:0]      r_end, lk_reach, new_end;
	logic             lk_miss, nl_fail, nh_fail, rc_fail, sh_done, out_free;
	logic [CNT_W:0]   ptr_inc;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t           wdata, rdata, new_rec;

	art_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign is_add = (item_q.cmd == CMD_ADD);
	assign is_rem = (item_q.cmd == CMD_REMOVE);
	assign is_lookup = (item_q.cmd == CMD_LOOKUP);
	assign addr = item_q.address;
	assign len = item_q.size_bytes;
	assign page64 = {32'd0, cfg.page_size};

	assign bad_arg = !cfg.enabled || addr == 64'd0 || len == 64'd0 ||
		cfg.page_size == 32'd0 || len > ~addr || item_q.access_rights == 4'd0 ||
		(item_q.access_rights & ~RIGHTS_VALID) != 4'd0 ||
		item_q.cache_kind != CACHE_NONE || item_q.range_mode > MODE_CAPACITY;

	always_comb begin
		prep_fin = 1'b0;
		prep_status = ST_OK;
		case (item_q.cmd)
			CMD_ADD: begin
				if (bad_arg) begin
					prep_fin = 1'b1;
					prep_status = ST_INVALID;
				end else if (count_q >= CNT_W'(TABLE_DEPTH) ||
					len > ~(page64 - 64'd1)) begin
					prep_fin = 1'b1;
					prep_status = ST_UNSUP;
				end
			end
			CMD_REMOVE: begin
				if (!cfg.enabled || addr == 64'd0) begin
					prep_fin = 1'b1;
					prep_status = ST_INVALID;
				end
			end
			CMD_LOOKUP: begin
				prep_fin = (len[31:0] == 32'd0) || (count_q == '0);
			end
			default: begin
				prep_fin = 1'b1;
				prep_status = ST_INVALID;
			end
		endcase
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W:1];

	// restoring remainder, one bit of the length per cycle
	assign rem_sh = {rem_q, len[bit_q]};
	assign rem_sub = rem_sh - {1'b0, cfg.page_size};
	assign rem_nx = (rem_sh >= {1'b0, cfg.page_size}) ? rem_sub[31:0] : rem_sh[31:0];
	assign gap = cfg.page_size - rem_q;

	assign cap_fail = next_off_q > cfg.capacity || extent_q > cfg.capacity - next_off_q;

	assign srch_done = (lo_q == hi_q);
	assign srch_fin = (is_lookup && lo_q == '0) || (is_rem && lo_q == count_q);
	assign pred = is_lookup ? (rdata.base <= addr) : (rdata.base < addr);

	assign r_end = {1'b0, rdata.base} + {1'b0, rdata.length};
	assign lk_off = addr - rdata.base;
	assign lk_miss = lk_off >= rdata.length;
	assign lk_reach = {1'b0, addr} + {33'd0, len[31:0]};
	assign new_end = {1'b0, addr} + {1'b0, len};
	assign nl_fail = (lo_q != '0) && (r_end > {1'b0, addr});
	assign nh_fail = (lo_q != count_q) && (new_end > {1'b0, rdata.base});
	assign rc_fail = (rdata.base != addr);

	assign ptr_inc = {1'b0, ptr_q} + 1'b1;
	assign sh_done = is_add ? (ptr_q == lo_q) : (ptr_inc >= {1'b0, count_q});
	assign out_free = !rsp_valid || rsp_ready;

	always_comb begin
		new_rec.base = addr;
		new_rec.length = len;
		new_rec.offset = next_off_q;
		new_rec.id = next_id_q;
		new_rec.mode = item_q.range_mode[0];
		new_rec.rights = item_q.access_rights[1:0];
		new_rec.stream = item_q.stream_tag;
	end

	always_comb begin
		res_out = res_q;
		res_out.entries_in_use = 7'(count_q);
	end

	always_comb begin
		raddr = lo_q[IDX_W-1:0];
		we = 1'b0;
		waddr = ptr_q[IDX_W-1:0];
		wdata = rdata;
		unique case (op)
			OP_SRD: raddr = mid[IDX_W-1:0];
			OP_LRD, OP_NLRD: raddr = IDX_W'(lo_q - 1'b1);
			OP_SH_RD: raddr = is_add ? IDX_W'(ptr_q - 1'b1) : ptr_inc[IDX_W-1:0];
			OP_SH_WR: we = 1'b1;
			OP_INS: begin
				we = 1'b1;
				waddr = lo_q[IDX_W-1:0];
				wdata = new_rec;
			end
			default: ;
		endcase
	end

	always_comb begin
		st = '0;
		st.rem_last = (bit_q == 6'd0);
		st.srch_done = srch_done;
		st.sh_done = sh_done;
		st.is_add = is_add;
		st.is_lookup = is_lookup;
		st.out_free = out_free;
		unique case (op)
			OP_PREP: st.fin = prep_fin;
			OP_CAP: st.fin = cap_fail;
			OP_SRD: st.fin = srch_done && srch_fin;
			OP_NLCHK: st.fin = nl_fail;
			OP_NHCHK: st.fin = nh_fail;
			OP_RCHK: st.fin = rc_fail;
			default: st.fin = 1'b0;
		endcase
	end

	// table bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			next_id_q <= '0;
			next_off_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (op == OP_INS) begin
				count_q <= count_q + 1'b1;
				next_id_q <= next_id_q + 32'd1;
				next_off_q <= next_off_q + extent_q;
			end
			if (op == OP_SH_RD && sh_done && !is_add) begin
				count_q <= count_q - 1'b1;
			end
			if (op == OP_DONE && out_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				item_q <= req;
				res_q <= '0;
			end
			OP_PREP: begin
				res_q.status <= prep_status;
				lo_q <= '0;
				hi_q <= count_q;
				rem_q <= '0;
				bit_q <= 6'd63;
			end
			OP_REM: begin
				rem_q <= rem_nx;
				bit_q <= bit_q - 6'd1;
			end
			OP_EXT: extent_q <= len + ((rem_q == 32'd0) ? 64'd0 : {32'd0, gap});
			OP_CAP: if (cap_fail) res_q.status <= ST_UNSUP;
			OP_SRD: if (srch_done && srch_fin && is_rem) res_q.status <= ST_INVALID;
			OP_SCMP: begin
				if (pred) lo_q <= mid + 1'b1;
				else hi_q <= mid;
			end
			OP_LCHK: begin
				if (!lk_miss) begin
					res_q.lookup_kind <= (lk_reach > r_end) ? KIND_CROSS : KIND_MATCH;
					res_q.hit_base <= rdata.base;
					res_q.hit_length <= rdata.length;
					res_q.hit_offset <= rdata.offset;
					res_q.hit_id <= rdata.id;
					res_q.hit_mode <= rdata.mode;
					res_q.hit_rights <= rdata.rights;
					res_q.hit_stream <= rdata.stream;
				end
			end
			OP_NLCHK: if (nl_fail) res_q.status <= ST_INVALID;
			OP_NHCHK: begin
				if (nh_fail) res_q.status <= ST_INVALID;
				ptr_q <= count_q;
			end
			OP_SH_WR: ptr_q <= is_add ? ptr_q - 1'b1 : ptr_inc[CNT_W-1:0];
			OP_INS: begin
				res_q.hit_base <= new_rec.base;
				res_q.hit_length <= new_rec.length;
				res_q.hit_offset <= new_rec.offset;
				res_q.hit_id <= new_rec.id;
				res_q.hit_mode <= new_rec.mode;
				res_q.hit_rights <= new_rec.rights;
				res_q.hit_stream <= new_rec.stream;
			end
			OP_RCHK: begin
				if (rc_fail) begin
					res_q.status <= ST_INVALID;
				end else begin
					res_q.hit_base <= rdata.base;
					res_q.hit_length <= rdata.length;
					res_q.hit_offset <= rdata.offset;
					res_q.hit_id <= rdata.id;
					res_q.hit_mode <= rdata.mode;
					res_q.hit_rights <= rdata.rights;
					res_q.hit_stream <= rdata.stream;
				end
				ptr_q <= lo_q;
			end
			OP_DONE: begin
				if (out_free) rsp <= res_out;
			end
			default: ;
		endcase
	end
endmodule

`default_nettype wire

// ===== rtl/address_range_table.sv =====
// Sorted address range table. Lookup: a binary search over the stored ranges
// (one RAM read per binary search probe) and a check of the entry found.
// Add: the page remainder of the length, the capacity check, the search, the entries shifted up.
// Remove: the search plus the entries shifted down. One item at a time;
// a finished result waits in the output register while the next item runs.
// Reset clears the count, id and offset counters and returns config to defaults;
// entry RAM is not cleared.
`default_nettype none

module address_range_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire art_pkg::req_t                req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output art_pkg::rsp_t                     rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [art_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [63:0]                  pwdata,
	output logic      [63:0]                  prdata,
	output logic                              pready
);
	import art_pkg::*;

	cfg_t    cfg_q;
	dp_op_t  op;
	dp_st_t  st;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b1;
			cfg_q.page_size <= 32'd4096;
			cfg_q.capacity <= 64'd0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ENABLE: cfg_q.enabled <= pwdata[0];
				REG_PAGE: cfg_q.page_size <= pwdata[31:0];
				REG_CAPACITY: cfg_q.capacity <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = {63'd0, cfg_q.enabled};
			REG_PAGE: prdata = {32'd0, cfg_q.page_size};
			REG_CAPACITY: prdata = cfg_q.capacity;
			default: prdata = 64'd0;
		endcase
	end

	art_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.op        (op)
	);

	art_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.op        (op),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule

`default_nettype wire

// ===== rtl/art_checker.sv =====
// Port-level checks for the address range table, bound to the top level.
// Depends on art_pkg and address_range_table.
`default_nettype none

module art_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire art_pkg::rsp_t rsp,
	input wire logic          pready
);
	import art_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.lookup_kind == KIND_NONE &&
		rsp.hit_base == 64'd0 && rsp.hit_id == 32'd0)
		else $error("failed item carries a record");

	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.lookup_kind != KIND_NONE |-> rsp.status == ST_OK &&
		rsp.hit_length != 64'd0)
		else $error("lookup hit with bad status or empty range");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entries_in_use <= 7'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind address_range_table art_checker u_chk (.*);

`default_nettype wire
